>>> src/audio_sample_format_converter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the audio sample format converter
// Implication checks that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef AUDIO_SAMPLE_FORMAT_CONVERTER_ASSERT_SVH
`define AUDIO_SAMPLE_FORMAT_CONVERTER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define ASFC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASFC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/asfc_pkg.sv
// ----------------------------------------------------------------------------
// asfc_pkg
// Shared types and constants of the audio sample format converter.
// ----------------------------------------------------------------------------
package asfc_pkg;

	localparam int WORD_W      = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W   = 3;

	// register reset values (binary32 bit patterns)
	localparam logic [WORD_W-1:0] VOLUME_RESET   = 32'h3F80_0000;
	localparam logic [WORD_W-1:0] SCALE_16_RESET = 32'h46FF_FE00;
	localparam logic [WORD_W-1:0] SCALE_24_RESET = 32'h4AFF_FFFE;
	localparam logic [WORD_W-1:0] SCALE_32_RESET = 32'h4F00_0000;

	// largest positive integer of each target range
	localparam logic [32:0] LIM_16 = 33'd32767;
	localparam logic [32:0] LIM_24 = 33'd8388607;
	localparam logic [32:0] LIM_32 = 33'd2147483647;

	typedef enum logic [1:0] {
		MODE_INT16      = 2'd0,
		MODE_INT32      = 2'd1,
		MODE_INT24_LEFT = 2'd2,
		MODE_SHIFT24    = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE     = 3'd0,
		REG_VOLUME   = 3'd1,
		REG_SCALE_16 = 3'd2,
		REG_SCALE_24 = 3'd3,
		REG_SCALE_32 = 3'd4
	} reg_index_t;

	// one queued transaction: mode, raw word and the scale picked for it
	typedef struct packed {
		mode_t             mode;
		logic [WORD_W-1:0] word;
		logic [WORD_W-1:0] scale;
	} item_t;

	// queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> src/asfc_fmul.sv
// ----------------------------------------------------------------------------
// asfc_fmul
// Three-stage binary32 multiplier, round to nearest even, with subnormals.
// ----------------------------------------------------------------------------
module asfc_fmul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] p
);
	import asfc_pkg::*;

	typedef enum logic [1:0] {FC_NUM, FC_ZERO, FC_INF, FC_NAN} fcls_t;

	typedef struct packed {
		logic               nan;
		logic               inf;
		logic               zero;
		logic signed [9:0]  e;
		logic [23:0]        m;
	} unpk_t;

	function automatic logic [4:0] lzc24(input logic [23:0] v);
		logic found;
		lzc24 = 5'd24;
		found = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!found && v[i]) begin
				lzc24 = 5'(23 - i);
				found = 1'b1;
			end
		end
	endfunction

	function automatic unpk_t unpack(input logic [31:0] w);
		unpk_t       u;
		logic [23:0] m;
		logic [4:0]  lz;
		u.nan  = (&w[30:23]) && (|w[22:0]);
		u.inf  = (&w[30:23]) && !(|w[22:0]);
		u.zero = (w[30:23] == 8'd0) && (w[22:0] == 23'd0);
		m      = {(w[30:23] != 8'd0), w[22:0]};
		lz     = lzc24(m);
		u.m    = m << lz;
		u.e    = ((w[30:23] == 8'd0) ? -10'sd126 : ($signed({2'b00, w[30:23]}) - 10'sd127))
			- $signed({5'd0, lz});
		return u;
	endfunction

	// stage 1: unpack and normalize operands, classify specials
	unpk_t             ua, ub;
	fcls_t             cls_c;
	logic              sign_s1, sign_s2;
	fcls_t             cls_s1, cls_s2;
	logic [23:0]       ma_s1, mb_s1;
	logic signed [9:0] e_s1, e_s2;
	logic [47:0]       prod_s2;

	always_comb begin
		ua = unpack(a);
		ub = unpack(b);
		if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf))
			cls_c = FC_NAN;
		else if (ua.inf || ub.inf)
			cls_c = FC_INF;
		else if (ua.zero || ub.zero)
			cls_c = FC_ZERO;
		else
			cls_c = FC_NUM;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sign_s1 <= a[31] ^ b[31];
			cls_s1  <= cls_c;
			ma_s1   <= ua.m;
			mb_s1   <= ub.m;
			e_s1    <= ua.e + ub.e;
		end
	end

	// stage 2: mantissa product
	always_ff @(posedge clk) begin
		if (en) begin
			sign_s2 <= sign_s1;
			cls_s2  <= cls_s1;
			prod_s2 <= ma_s1 * mb_s1;
			e_s2    <= e_s1;
		end
	end

	// stage 3: normalize, round and pack
	logic signed [9:0] e_n, e_b, d_full;
	logic [47:0]       q, sh;
	logic [4:0]        d;
	logic [30:0]       base, mag;
	logic              g, st, lsb, ovf;
	logic [31:0]       p_c;

	always_comb begin
		e_n    = prod_s2[47] ? (e_s2 + 10'sd1) : e_s2;
		q      = prod_s2[47] ? prod_s2 : (prod_s2 << 1);
		e_b    = e_n + 10'sd127;
		d_full = -10'sd126 - e_n;
		d      = (d_full > 10'sd25) ? 5'd25 : d_full[4:0];
		sh     = q >> d;
		ovf    = 1'b0;
		base   = '0;
		g      = 1'b0;
		st     = 1'b0;
		lsb    = 1'b0;
		if (e_n > 10'sd127) begin
			ovf = 1'b1;
		end else if (e_n >= -10'sd126) begin
			base = {e_b[7:0], q[46:24]};
			g    = q[23];
			st   = |q[22:0];
			lsb  = q[24];
		end else begin
			// subnormal result: shift out and fold lost bits into sticky
			base = {8'd0, sh[46:24]};
			g    = sh[23];
			st   = (|sh[22:0]) || (|(q & ((48'd1 << d) - 48'd1)));
			lsb  = sh[24];
		end
		mag = ovf ? {8'hFF, 23'd0} : (base + 31'(g && (st || lsb)));
		case (cls_s2)
			FC_NAN:  p_c = 32'h7FC0_0000;
			FC_INF:  p_c = {sign_s2, 8'hFF, 23'd0};
			FC_ZERO: p_c = {sign_s2, 31'd0};
			default: p_c = {sign_s2, mag};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			p <= p_c;
	end

endmodule

>>> src/asfc_queue.sv
// ----------------------------------------------------------------------------
// asfc_queue
// Short transaction queue between the front and the back.
// ----------------------------------------------------------------------------
module asfc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  asfc_pkg::item_t     push_item,
	input  logic                pop,
	output asfc_pkg::item_t     head_item,
	output asfc_pkg::q_status_t stat
);
	import asfc_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head_item  = mem_q[rd_ptr_q];

	// store pushed transactions
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

endmodule

>>> src/asfc_front.sv
// ----------------------------------------------------------------------------
// asfc_front
// Configuration registers, input acceptance and per-mode scale selection.
// ----------------------------------------------------------------------------
module asfc_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [asfc_pkg::WORD_W-1:0]            sample_word,
	input  logic                                   cfg_wr_en,
	input  logic [asfc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [asfc_pkg::WORD_W-1:0]            cfg_wdata,
	input  asfc_pkg::q_status_t                    q_stat,
	output logic                                   push,
	output asfc_pkg::item_t                        push_item,
	output asfc_pkg::mode_t                        mode,
	output logic [asfc_pkg::WORD_W-1:0]            volume
);
	import asfc_pkg::*;

	mode_t             mode_q;
	logic [WORD_W-1:0] volume_q, scale_16_q, scale_24_q, scale_32_q;

	// register writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_INT16;
			volume_q   <= VOLUME_RESET;
			scale_16_q <= SCALE_16_RESET;
			scale_24_q <= SCALE_24_RESET;
			scale_32_q <= SCALE_32_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MODE:     mode_q     <= mode_t'(cfg_wdata[1:0]);
				REG_VOLUME:   volume_q   <= cfg_wdata;
				REG_SCALE_16: scale_16_q <= cfg_wdata;
				REG_SCALE_24: scale_24_q <= cfg_wdata;
				REG_SCALE_32: scale_32_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// classify: pick the scale for the current mode
	always_comb begin
		push_item.mode = mode_q;
		push_item.word = sample_word;
		case (mode_q)
			MODE_INT16:      push_item.scale = scale_16_q;
			MODE_INT32:      push_item.scale = scale_32_q;
			MODE_INT24_LEFT: push_item.scale = scale_24_q;
			default:         push_item.scale = '0;
		endcase
	end

	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;
	assign mode     = mode_q;
	assign volume   = volume_q;

endmodule

>>> src/asfc_back.sv
// ----------------------------------------------------------------------------
// asfc_back
// Two chained float multiplies, truncation, saturation and output register.
// ----------------------------------------------------------------------------
module asfc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  asfc_pkg::q_status_t               q_stat,
	input  asfc_pkg::item_t                   head_item,
	output logic                              pop,
	input  logic [asfc_pkg::WORD_W-1:0]       volume,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [asfc_pkg::WORD_W-1:0] sample_out,
	output logic                              clipped
);
	import asfc_pkg::*;

	localparam int SIDE_DEPTH = 6;

	typedef struct packed {
		mode_t             mode;
		logic [WORD_W-1:0] word;
	} side_t;

	logic                  en;
	logic [SIDE_DEPTH-1:0] vld_s;
	side_t                 side_s [SIDE_DEPTH];
	logic [WORD_W-1:0]     t_prod, p_prod;

	// whole pipe moves unless a finished result is held
	assign en  = !(out_valid && out_stall);
	assign pop = en && !q_stat.empty;

	asfc_fmul u_mul_scale (
		.clk (clk),
		.en  (en),
		.a   (head_item.word),
		.b   (head_item.scale),
		.p   (t_prod)
	);

	asfc_fmul u_mul_volume (
		.clk (clk),
		.en  (en),
		.a   (t_prod),
		.b   (volume),
		.p   (p_prod)
	);

	// carry valid and mode alongside the multipliers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[SIDE_DEPTH-2:0], pop};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= {head_item.mode, head_item.word};
			for (int i = 1; i < SIDE_DEPTH; i++)
				side_s[i] <= side_s[i-1];
		end
	end

	// truncation stage: integer magnitude toward zero, capped at 33 bits
	logic [7:0]  p_exp;
	logic [23:0] p_man;
	logic [32:0] tm_c;
	logic        vld_t1;
	side_t       side_t1;
	logic        sign_t1, nan_t1;
	logic [32:0] tm_t1;

	always_comb begin
		p_exp = p_prod[30:23];
		p_man = {1'b1, p_prod[22:0]};
		if (p_exp >= 8'd159)
			tm_c = '1;
		else if (p_exp < 8'd127)
			tm_c = '0;
		else if (p_exp <= 8'd150)
			tm_c = {9'd0, p_man >> (8'd150 - p_exp)};
		else
			tm_c = {9'd0, p_man} << (p_exp - 8'd150);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_t1 <= 1'b0;
		else if (en)
			vld_t1 <= vld_s[SIDE_DEPTH-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_t1 <= side_s[SIDE_DEPTH-1];
			sign_t1 <= p_prod[31];
			nan_t1  <= (&p_exp) && (|p_prod[22:0]);
			tm_t1   <= tm_c;
		end
	end

	// saturate to the target range and format
	logic [32:0]       lim;
	logic              clip_hi, clip_lo;
	logic [WORD_W-1:0] val_c;
	logic              clip_c;

	always_comb begin
		case (side_t1.mode)
			MODE_INT16:      lim = LIM_16;
			MODE_INT32:      lim = LIM_32;
			default:         lim = LIM_24;
		endcase
		clip_hi = !sign_t1 && (tm_t1 > lim);
		clip_lo = sign_t1 && (tm_t1 > (lim + 33'd1));
		if (nan_t1)
			val_c = '0;
		else if (clip_hi)
			val_c = lim[WORD_W-1:0];
		else if (clip_lo)
			val_c = ~lim[WORD_W-1:0];
		else if (sign_t1)
			val_c = -tm_t1[WORD_W-1:0];
		else
			val_c = tm_t1[WORD_W-1:0];
		clip_c = nan_t1 || clip_hi || clip_lo;
		case (side_t1.mode)
			MODE_INT24_LEFT: val_c = val_c << 8;
			MODE_SHIFT24: begin
				val_c  = {{8{side_t1.word[31]}}, side_t1.word[31:8]};
				clip_c = 1'b0;
			end
			default: ;
		endcase
	end

	// output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= vld_t1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_out <= $signed(val_c);
			clipped    <= clip_c;
		end
	end

endmodule

>>> src/audio_sample_format_converter.sv
// ----------------------------------------------------------------------------
// audio_sample_format_converter
// Converts float32 (or raw int32) samples to int16, int32 or 24-bit PCM.
// Input channel: in_valid / in_stall carry sample_word; a transaction is taken
// when in_valid is high and in_stall low. Output channel: out_valid /
// out_stall carry sample_out and clipped. Registers are written through
// cfg_wr_en / cfg_index / cfg_wdata; the user must write them only while no
// sample is in flight, which the block itself does not enforce. Path from
// input to out_valid: queue, two 3-stage float multipliers, truncation and
// output register. Throughput: one sample per cycle while out_stall is low.
// Reset clears the queue and pipeline valids and loads mode 0, volume 1.0
// and the default full-scale factors. When out_stall is high while out_valid
// is set, the output and the pipeline hold; the 4-entry queue keeps taking
// input until it is full, then in_stall rises.
// ----------------------------------------------------------------------------
`include "audio_sample_format_converter_assert.svh"

module audio_sample_format_converter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [asfc_pkg::WORD_W-1:0]         sample_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [asfc_pkg::WORD_W-1:0]  sample_out,
	output logic                                clipped,
	input  logic                                cfg_wr_en,
	input  logic [asfc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [asfc_pkg::WORD_W-1:0]         cfg_wdata
);
	import asfc_pkg::*;

	q_status_t         q_stat;
	item_t             push_item, head_item;
	logic              push, pop;
	mode_t             mode;
	logic [WORD_W-1:0] volume;

	asfc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_word (sample_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.q_stat      (q_stat),
		.push        (push),
		.push_item   (push_item),
		.mode        (mode),
		.volume      (volume)
	);

	asfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.stat      (q_stat)
	);

	asfc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.head_item  (head_item),
		.pop        (pop),
		.volume     (volume),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.clipped    (clipped)
	);

	// shift mode never clips
	`ASFC_ASSERT_IMPLIES(a_shift_no_clip, clk, arst_n, out_valid && (mode == MODE_SHIFT24), !clipped)
	// left-aligned 24-bit output keeps its low byte clear
	`ASFC_ASSERT_IMPLIES(a_left24_low_zero, clk, arst_n, out_valid && (mode == MODE_INT24_LEFT), sample_out[7:0] == 8'd0)
	// int16 output stays in range
	`ASFC_ASSERT_IMPLIES(a_int16_range, clk, arst_n, out_valid && (mode == MODE_INT16), (sample_out >= -32'sd32768) && (sample_out <= 32'sd32767))
	// a full queue raises stall on the next cycle when nothing drains
	`ASFC_ASSERT_NEXT(a_fill_stalls, clk, arst_n, push && !pop && (u_queue.count_q == 3'd3), in_stall)

endmodule
